// File: src/mcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcfc_pkg;

	localparam logic [2:0] REG_FRAC_LOW    = 3'd0;
	localparam logic [2:0] REG_FRAC_HIGH   = 3'd1;
	localparam logic [2:0] REG_MIN_KEEP    = 3'd2;
	localparam logic [2:0] REG_MASKED_BITS = 3'd3;
	localparam logic [2:0] REG_CLIPPED_BIT = 3'd4;

	typedef struct packed {
		logic [15:0] frac_low;
		logic [15:0] frac_high;
		logic [6:0]  min_keep;
		logic [7:0]  masked_bits;
		logic [7:0]  clipped_bit;
	} cfg_t;

	// one loaded value as it travels from the front to the store
	typedef struct packed {
		logic signed [31:0] sample;
		logic [7:0]         mask;
		logic               ok;
		logic               last;
	} item_t;

endpackage
`default_nettype wire

// File: src/mcfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfc_front (
	input  wire mcfc_pkg::cfg_t cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire signed [31:0]   sample,
	input  wire [7:0]           in_mask,
	input  wire                 last_sample,
	output logic                push,
	output mcfc_pkg::item_t     push_item,
	input  wire                 q_ready
);
	logic [7:0] excl;

	assign excl = cfg.masked_bits | cfg.clipped_bit;
	assign in_ready = q_ready;
	assign push = in_valid & q_ready;

	always_comb begin
		push_item.sample = sample;
		push_item.mask   = in_mask;
		push_item.ok     = ((in_mask & excl) == 8'd0);
		push_item.last   = last_sample;
	end

endmodule
`default_nettype wire

// File: src/mcfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire mcfc_pkg::item_t d,
	output logic                ready,
	input  wire                 pop,
	output mcfc_pkg::item_t     head,
	output logic                valid
);
	mcfc_pkg::item_t slot0_q, slot1_q;
	logic [1:0]      cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				slot0_q <= d;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= d;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= d;
			end else begin
				slot1_q <= d;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire

// File: src/mcfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfc_back #(
	parameter int MAX_VALUES = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire mcfc_pkg::cfg_t cfg,
	input  wire                 q_valid,
	input  wire mcfc_pkg::item_t q_head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [5:0]          position,
	output logic [7:0]          out_mask,
	output logic [6:0]          total_clipped,
	output logic                last_result
);
	localparam int IW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int CW = $clog2(MAX_VALUES + 1);
	localparam int KW = CW + 25;
	localparam logic [CW-1:0] MAXC = CW'(MAX_VALUES);
	localparam logic [CW-1:0] ONE  = CW'(1);

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_MUL0   = 4'd1;
	localparam logic [3:0] ST_MUL1   = 4'd2;
	localparam logic [3:0] ST_MUL2   = 4'd3;
	localparam logic [3:0] ST_DECIDE = 4'd4;
	localparam logic [3:0] ST_RDK    = 4'd5;
	localparam logic [3:0] ST_LATK   = 4'd6;
	localparam logic [3:0] ST_SCAN   = 4'd7;
	localparam logic [3:0] ST_PUT    = 4'd8;

	mcfc_pkg::item_t mem [MAX_VALUES];
	mcfc_pkg::item_t rd_q;
	logic [IW-1:0]   raddr;
	logic            we;

	logic [3:0]     state_q;
	logic [CW-1:0]  cnt_q, vcnt_q, k_q, j_q, rank_q;
	logic [CW-1:0]  nl_q, nh_q, thr_q, total_q;
	logic [IW-1:0]  jd_q;
	logic           cmp_v_q;
	logic signed [31:0] key_q;
	logic [7:0]     kmask_q;
	logic           kok_q;
	logic signed [KW-1:0] prod_q, mul_a, mul_b;
	logic signed [17:0]   keep_f;
	logic                 apply;
	logic [CW-1:0]        hi_start, rest, nh_eff;
	logic                 clip, before_k;
	logic [CW+5:0]        pos_ext;
	logic [CW+6:0]        tot_ext;

	logic                 out_valid_q, last_q;
	logic [5:0]           pos_q;
	logic [7:0]           omask_q;
	logic [6:0]           tot_q;

	assign pop = (state_q == ST_LOAD) && q_valid;
	assign we  = pop && (cnt_q < MAXC);
	assign raddr = (state_q == ST_SCAN) ? j_q[IW-1:0] : k_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cnt_q[IW-1:0]] <= q_head;
		end
		rd_q <= mem[raddr];
	end

	// shared multiplier for the three products of the count
	assign keep_f = 18'sh10000 - $signed({2'b00, cfg.frac_low}) - $signed({2'b00, cfg.frac_high});
	always_comb begin
		mul_a = $signed(KW'(vcnt_q));
		case (state_q)
			ST_MUL0: mul_b = $signed(KW'(cfg.frac_low));
			ST_MUL1: mul_b = $signed(KW'(cfg.frac_high));
			default: mul_b = KW'(keep_f);
		endcase
	end

	assign apply = ((cfg.frac_low != 16'd0) || (cfg.frac_high != 16'd0))
		&& (cfg.clipped_bit != 8'd0)
		&& (prod_q >= $signed(KW'({cfg.min_keep, 16'd0})));
	assign rest     = vcnt_q - nl_q;
	assign hi_start = vcnt_q - nh_q;
	assign nh_eff   = (nh_q < rest) ? nh_q : rest;

	assign before_k = (CW'(jd_q) < k_q);
	assign clip = kok_q && ((rank_q < nl_q) || (rank_q >= thr_q));
	assign pos_ext = {6'd0, k_q};
	assign tot_ext = {7'd0, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUT) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			vcnt_q      <= '0;
			k_q         <= '0;
			j_q         <= '0;
			cmp_v_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (cnt_q < MAXC) begin
							cnt_q  <= cnt_q + ONE;
							vcnt_q <= vcnt_q + CW'(q_head.ok);
						end
						if (q_head.last) begin
							state_q <= ST_MUL0;
						end
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					k_q     <= '0;
					state_q <= ST_RDK;
				end
				ST_RDK: state_q <= ST_LATK;
				ST_LATK: begin
					j_q     <= '0;
					cmp_v_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == cnt_q) begin
						cmp_v_q <= 1'b0;
						state_q <= ST_PUT;
					end else begin
						j_q     <= j_q + ONE;
						cmp_v_q <= 1'b1;
					end
				end
				ST_PUT: begin
					if (!out_valid_q || out_ready) begin
						if (k_q + ONE == cnt_q) begin
							cnt_q   <= '0;
							vcnt_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + ONE;
							state_q <= ST_RDK;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL0: prod_q <= mul_a * mul_b;
			ST_MUL1: begin
				nl_q   <= prod_q[16 +: CW];
				prod_q <= mul_a * mul_b;
			end
			ST_MUL2: begin
				nh_q   <= prod_q[16 +: CW];
				prod_q <= mul_a * mul_b;
			end
			ST_DECIDE: begin
				if (!apply) begin
					nl_q    <= '0;
					thr_q   <= vcnt_q;
					total_q <= '0;
				end else begin
					thr_q   <= (hi_start > nl_q) ? hi_start : nl_q;
					total_q <= nl_q + nh_eff;
				end
			end
			ST_LATK: begin
				key_q   <= rd_q.sample;
				kmask_q <= rd_q.mask;
				kok_q   <= rd_q.ok;
				rank_q  <= '0;
			end
			ST_SCAN: begin
				jd_q <= j_q[IW-1:0];
				if (cmp_v_q && rd_q.ok
						&& ((rd_q.sample < key_q) || ((rd_q.sample == key_q) && before_k))) begin
					rank_q <= rank_q + ONE;
				end
			end
			ST_PUT: begin
				if (!out_valid_q || out_ready) begin
					pos_q   <= pos_ext[5:0];
					omask_q <= clip ? (kmask_q | cfg.clipped_bit) : kmask_q;
					tot_q   <= tot_ext[6:0];
					last_q  <= (k_q + ONE == cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign position      = pos_q;
	assign out_mask      = omask_q;
	assign total_clipped = tot_q;
	assign last_result   = last_q;

endmodule
`default_nettype wire

// File: src/minmax_fraction_clipper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake          | beat
// in      | in  | in_valid/in_ready  | sample, in_mask, last_sample
// out     | out | out_valid/out_ready | position, out_mask, total_clipped, last_result
// cfg     | in  | cfg_we             | cfg_idx, cfg_data
// Values load into the sample store through a two-beat queue, one per cycle while the
// back end is loading. After the last value the count arithmetic runs (MUL0, MUL1, MUL2,
// DECIDE), then for each value: one store read for the value, a rank scan over the n
// stored values, one output beat. The key read and the scan share the single store
// read port.
// Reset clears control only; out_ready low holds the output beat and stops the back end before its next beat.
module minmax_fraction_clipper_core #(
	parameter int MAX_VALUES = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_idx,
	input  wire [15:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire signed [31:0] sample,
	input  wire [7:0]         in_mask,
	input  wire               last_sample,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [5:0]        position,
	output logic [7:0]        out_mask,
	output logic [6:0]        total_clipped,
	output logic              last_result
);
	mcfc_pkg::cfg_t  cfg_q;
	mcfc_pkg::item_t push_item, head;
	logic            push, q_ready, q_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frac_low    <= 16'd0;
			cfg_q.frac_high   <= 16'd0;
			cfg_q.min_keep    <= 7'd0;
			cfg_q.masked_bits <= 8'd0;
			cfg_q.clipped_bit <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				mcfc_pkg::REG_FRAC_LOW:    cfg_q.frac_low    <= cfg_data;
				mcfc_pkg::REG_FRAC_HIGH:   cfg_q.frac_high   <= cfg_data;
				mcfc_pkg::REG_MIN_KEEP:    cfg_q.min_keep    <= cfg_data[6:0];
				mcfc_pkg::REG_MASKED_BITS: cfg_q.masked_bits <= cfg_data[7:0];
				mcfc_pkg::REG_CLIPPED_BIT: cfg_q.clipped_bit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mcfc_front u_front (
		.cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample(sample), .in_mask(in_mask), .last_sample(last_sample),
		.push(push), .push_item(push_item), .q_ready(q_ready)
	);

	mcfc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .d(push_item), .ready(q_ready),
		.pop(pop), .head(head), .valid(q_valid)
	);

	mcfc_back #(.MAX_VALUES(MAX_VALUES)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_head(head), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .out_mask(out_mask),
		.total_clipped(total_clipped), .last_result(last_result)
	);

endmodule
`default_nettype wire

// File: src/mcfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [5:0] position,
	input wire [7:0] out_mask,
	input wire [6:0] total_clipped,
	input wire       last_result
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(out_mask)
			&& $stable(total_clipped) && $stable(last_result))
		else $error("output beat changed while stalled");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_clipped <= 7'd64)
		else $error("clipped total out of range");

	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid))
		else $error("out_valid unknown");

	a_beat_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({position, out_mask, total_clipped, last_result}))
		else $error("output beat has unknown bits");

endmodule

bind minmax_fraction_clipper_core mcfc_checker u_mcfc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.position(position), .out_mask(out_mask), .total_clipped(total_clipped),
	.last_result(last_result)
);
`default_nettype wire
